### sv/mthw_pkg.sv
// Shared constants, codes and result word layout for the heartbeat watchdog.
package mthw_pkg;

	localparam int MAX_TASKS = 8;
	localparam int TICK_BITS = 32;
	localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	localparam int DEADLINE_W = 32;
	localparam int RELOAD_W   = 12;
	localparam int DIV_W      = 9;
	localparam int PRESC_W    = 8;
	localparam int CMP_W      = (TICK_BITS > DEADLINE_W) ? TICK_BITS : DEADLINE_W;

	localparam logic [DEADLINE_W-1:0] DEADLINE_RST = DEADLINE_W'(2000);
	localparam logic [RELOAD_W-1:0]   RELOAD_RST   = RELOAD_W'(1875);
	localparam logic [DIV_W-1:0]      DIVIDER_RST  = DIV_W'(64);
	localparam logic [RELOAD_W-1:0]   WDT_RESET_LOAD = RELOAD_W'(1875);
	localparam logic [DIV_W-1:0]      DIV_MAX      = DIV_W'(256);

	typedef enum logic [2:0] {
		FN_TICK     = 3'd0,
		FN_WDCLK    = 3'd1,
		FN_REGISTER = 3'd2,
		FN_CHECKIN  = 3'd3,
		FN_CHECK    = 3'd4,
		FN_QUERY    = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		REG_DEADLINE = 2'd0,
		REG_RELOAD   = 2'd1,
		REG_DIVIDER  = 2'd2,
		REG_ENABLE   = 2'd3
	} reg_idx_t;

	// result word, listed from the top bit down
	typedef struct packed {
		logic [3:0] pad;
		logic [3:0] task_count;
		logic       reset_request;
		logic [7:0] stalled_mask;
		logic       fed;
		logic       no_stall;
		logic       stalled;
		logic       accepted;
		logic [2:0] slot_out;
	} result_t;

endpackage

### sv/multi_task_heartbeat_watchdog.sv
// Top level of the multi-task heartbeat watchdog: control, watchdog counter and slot table.
//
// Clients take slots with a register event and refresh them with checkin; a slot is
// stalled once the wrapped tick distance since its last heartbeat exceeds deadline_ticks.
// A check event walks the registered slots and reloads the watchdog down-counter only if
// none is stalled; when the counter expires on a watchdog clock event the result word
// carries reset_request and the tick count, slot table and prescaler are cleared
// (configuration registers keep their values). Every input word gives exactly one result
// word. Heartbeat times live in a small synchronous RAM with registered read data, so
// the check walk issues one read per cycle. After acceptance, tick, watchdog clock,
// register and checkin results go straight to the output register; a query of a
// registered slot first passes one RAM read, and a check reads the registered slots in
// turn, compares each one behind its read and then closes the walk (with an empty table
// nothing is read). The input is taken again the cycle after the result has moved to
// the output register, even if that word has not been taken yet. While the output
// register still holds an untaken word, the next result waits and the input stalls.
// No clearing pass is needed after reset; slots beyond the fill count are never read.
module multi_task_heartbeat_watchdog (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input word
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] slot, [7:4] zero
	input  logic [2:0]  s_tuser,   // [2:0] func
	// result word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [2:0] slot_out, [3] accepted, [4] stalled,
	                               // [5] no_stall, [6] fed, [14:7] stalled_mask,
	                               // [15] reset_request, [19:16] task_count, [23:20] zero
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_QRY,
		ST_OUT
	} state_t;

	// configuration registers
	logic [mthw_pkg::DEADLINE_W-1:0] deadline_q;
	logic [mthw_pkg::RELOAD_W-1:0]   reload_q;
	logic [mthw_pkg::DIV_W-1:0]      div_q;
	logic                            en_q;

	// control and watchdog state
	state_t                         state_q;
	logic [mthw_pkg::TICK_BITS-1:0] tick_q;
	logic [mthw_pkg::CNT_W-1:0]     used_q;
	logic [mthw_pkg::RELOAD_W-1:0]  wdt_cnt_q;
	logic [mthw_pkg::PRESC_W-1:0]   presc_q;
	logic [mthw_pkg::CNT_W-1:0]     idx_q;
	logic                           rd_pend_s1;
	logic [mthw_pkg::SLOT_W-1:0]    rd_idx_s1;
	logic [mthw_pkg::MAX_TASKS-1:0] mask_q;
	mthw_pkg::result_t              res_q;
	mthw_pkg::result_t              out_q;
	logic                           m_tvalid_q;

	// datapath
	mthw_pkg::func_t                func_in;
	logic [3:0]                     slot_in;
	logic                           slot_ok;
	logic                           reg_ok;
	logic                           ram_we;
	logic [mthw_pkg::SLOT_W-1:0]    ram_waddr;
	logic [mthw_pkg::SLOT_W-1:0]    ram_raddr;
	logic [mthw_pkg::TICK_BITS-1:0] ram_rdata;
	logic [mthw_pkg::TICK_BITS-1:0] elapsed;
	logic                           stall_rd;
	logic [mthw_pkg::DIV_W-1:0]     div_eff;
	logic                           presc_wrap;
	logic                           wd_expire;
	logic                           walk_done;
	logic                           out_load;
	mthw_pkg::result_t              acc_res;
	mthw_pkg::result_t              chk_res;
	logic                           cfg_wr;
	mthw_pkg::reg_idx_t             cfg_idx;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_idx  = mthw_pkg::reg_idx_t'(paddr[3:2]);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	assign func_in  = mthw_pkg::func_t'(s_tuser);
	assign slot_in  = s_tdata[3:0];
	// slots fill in order and clear together, so valid means below the fill count
	assign slot_ok  = ({1'b0, slot_in} < {1'b0, used_q});
	assign reg_ok   = (used_q < mthw_pkg::CNT_W'(mthw_pkg::MAX_TASKS));

	// heartbeat writes happen only on accept in idle; reads serve the walk or a query
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = mthw_pkg::SLOT_W'(slot_in);
		if (state_q == ST_IDLE && s_tvalid) begin
			if (func_in == mthw_pkg::FN_REGISTER) begin
				ram_we    = reg_ok;
				ram_waddr = mthw_pkg::SLOT_W'(used_q);
			end else if (func_in == mthw_pkg::FN_CHECKIN) begin
				ram_we    = slot_ok;
			end
		end
		ram_raddr = (state_q == ST_WALK) ? mthw_pkg::SLOT_W'(idx_q)
		                                 : mthw_pkg::SLOT_W'(slot_in);
	end

	mthw_ram #(
		.WIDTH(mthw_pkg::TICK_BITS),
		.DEPTH(mthw_pkg::MAX_TASKS)
	) u_last_seen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(tick_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// wrapped distance since last heartbeat against the deadline
	assign elapsed  = tick_q - ram_rdata;
	assign stall_rd = (mthw_pkg::CMP_W'(elapsed) > mthw_pkg::CMP_W'(deadline_q));

	// divider: zero acts as one, anything above 256 as 256
	always_comb begin
		if (div_q == '0) begin
			div_eff = mthw_pkg::DIV_W'(1);
		end else if (div_q > mthw_pkg::DIV_MAX) begin
			div_eff = mthw_pkg::DIV_MAX;
		end else begin
			div_eff = div_q;
		end
	end
	assign presc_wrap = ({1'b0, presc_q} + mthw_pkg::DIV_W'(1)) >= div_eff;
	assign wd_expire  = en_q && presc_wrap && (wdt_cnt_q <= mthw_pkg::RELOAD_W'(1));

	assign walk_done  = (idx_q >= used_q) && !rd_pend_s1;
	assign out_load   = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// result fields settled at accept time
	always_comb begin
		acc_res            = '0;
		acc_res.task_count = 4'(used_q);
		case (func_in)
			mthw_pkg::FN_WDCLK: begin
				if (wd_expire) begin
					acc_res.reset_request = 1'b1;
					acc_res.task_count    = '0;
				end
			end
			mthw_pkg::FN_REGISTER: begin
				if (reg_ok) begin
					acc_res.slot_out   = 3'(used_q);
					acc_res.accepted   = 1'b1;
					acc_res.task_count = 4'(used_q + 1'b1);
				end
			end
			mthw_pkg::FN_CHECKIN: begin
				acc_res.accepted = slot_ok;
			end
			default: ;
		endcase
	end

	// check result once the walk has finished
	always_comb begin
		chk_res              = res_q;
		chk_res.stalled_mask = 8'(mask_q);
		chk_res.no_stall     = (mask_q == '0);
		chk_res.fed          = (mask_q == '0);
	end

	always_comb begin
		case (cfg_idx)
			mthw_pkg::REG_DEADLINE: prdata = 32'(deadline_q);
			mthw_pkg::REG_RELOAD:   prdata = 32'(reload_q);
			mthw_pkg::REG_DIVIDER:  prdata = 32'(div_q);
			mthw_pkg::REG_ENABLE:   prdata = 32'(en_q);
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= mthw_pkg::DEADLINE_RST;
			reload_q   <= mthw_pkg::RELOAD_RST;
			div_q      <= mthw_pkg::DIVIDER_RST;
			en_q       <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mthw_pkg::REG_DEADLINE: deadline_q <= pwdata[mthw_pkg::DEADLINE_W-1:0];
				mthw_pkg::REG_RELOAD:   reload_q   <= pwdata[mthw_pkg::RELOAD_W-1:0];
				mthw_pkg::REG_DIVIDER:  div_q      <= pwdata[mthw_pkg::DIV_W-1:0];
				mthw_pkg::REG_ENABLE:   en_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_q     <= '0;
			used_q     <= '0;
			wdt_cnt_q  <= mthw_pkg::WDT_RESET_LOAD;
			presc_q    <= '0;
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
			rd_idx_s1  <= '0;
			mask_q     <= '0;
			res_q      <= '0;
			out_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output register: load a finished result, else drop a taken word
			if (out_load) begin
				out_q      <= res_q;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						res_q <= acc_res;
						if (func_in == mthw_pkg::FN_CHECK) begin
							state_q <= ST_WALK;
						end else if (func_in == mthw_pkg::FN_QUERY && slot_ok) begin
							state_q <= ST_QRY;
						end else begin
							state_q <= ST_OUT;
						end
						case (func_in)
							mthw_pkg::FN_TICK: begin
								tick_q <= tick_q + 1'b1;
							end
							mthw_pkg::FN_WDCLK: begin
								if (en_q) begin
									if (presc_wrap) begin
										presc_q <= '0;
										if (wd_expire) begin
											// expiry: clear ticks, table and prescaler
											tick_q    <= '0;
											used_q    <= '0;
											wdt_cnt_q <= reload_q;
										end else begin
											wdt_cnt_q <= wdt_cnt_q - 1'b1;
										end
									end else begin
										presc_q <= presc_q + 1'b1;
									end
								end
							end
							mthw_pkg::FN_REGISTER: begin
								if (reg_ok) begin
									used_q <= used_q + 1'b1;
								end
							end
							mthw_pkg::FN_CHECK: begin
								idx_q      <= '0;
								mask_q     <= '0;
								rd_pend_s1 <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					// read slot idx while comparing the slot read last cycle
					if (rd_pend_s1 && stall_rd) begin
						mask_q[rd_idx_s1] <= 1'b1;
					end
					if (idx_q < used_q) begin
						rd_pend_s1 <= 1'b1;
						rd_idx_s1  <= mthw_pkg::SLOT_W'(idx_q);
						idx_q      <= idx_q + 1'b1;
					end else begin
						rd_pend_s1 <= 1'b0;
					end
					if (walk_done) begin
						res_q <= chk_res;
						if (mask_q == '0) begin
							wdt_cnt_q <= reload_q;
						end
						state_q <= ST_OUT;
					end
				end
				ST_QRY: begin
					res_q.stalled <= stall_rd;
					state_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= mthw_pkg::CNT_W'(mthw_pkg::MAX_TASKS))
		else $error("slot fill count beyond table size");

	a_feed_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && walk_done && mask_q == '0) |=> (wdt_cnt_q == $past(reload_q)))
		else $error("healthy check did not reload watchdog counter");

	a_fed_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q.fed) |-> (out_q.no_stall && out_q.stalled_mask == '0))
		else $error("feed reported with stalled slots");

	a_expiry_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q.reset_request) |-> (out_q.task_count == '0))
		else $error("expiry word shows registered slots");

endmodule

### sv/mthw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mthw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### bench/tb.sv
// Self-checking bench for the multi-task heartbeat watchdog: stream driver, monitor, predictor.
module tb;

	// func codes the block has no name for; they must leave all state alone
	localparam logic [2:0] FN_UNDEF_6 = 3'd6;
	localparam logic [2:0] FN_UNDEF_7 = 3'd7;

	localparam int QUIET_LIMIT   = 4000; // cycles with no word moving on either side
	localparam int SETTLE_CYCLES = 20;   // pause after the last result before the next phase
	localparam int HOLD_CYCLES   = 400;  // long receiver back-pressure stretch
	localparam int PHASE_WORDS   = 148;
	localparam int NUM_PHASES    = 9;
	localparam int MAX_REPORTS   = 100;

	typedef struct {
		logic [2:0] func;
		logic [3:0] slot;
	} hb_word_t;

	// ---------------------------------------------------------------- DUT ports
	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0; // [3:0] slot, [7:4] zero
	logic [2:0]  s_tuser  = '0; // [2:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // [2:0] slot_out, [3] accepted, [4] stalled,
	                            // [5] no_stall, [6] fed, [14:7] stalled_mask,
	                            // [15] reset_request, [19:16] task_count, [23:20] zero

	multi_task_heartbeat_watchdog dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- bench state
	hb_word_t              word_q[$];           // words waiting for the driver
	mthw_pkg::result_t     expected_results[$]; // predicted result words, oldest first
	int unsigned words_queued = 0;
	int unsigned words_sent = 0;
	int unsigned results_checked = 0;
	int unsigned fail_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_hold_reqs = 0;    // bumped by the sequencer, served by the monitor
	int unsigned n_expiry = 0;
	int unsigned n_late_checks = 0;
	int unsigned n_full = 0;
	int unsigned n_settings = 0;

	// ---------------------------------------------------------------- predictor
	// Shadow copy of the configuration registers.
	logic [31:0] deadline_cfg;
	logic [11:0] reload_cfg;
	logic [8:0]  divider_cfg;
	logic        enable_cfg;

	// Shadow copy of the block state.
	logic [31:0] tick_now;
	logic [31:0] heartbeat [mthw_pkg::MAX_TASKS];
	logic        live [mthw_pkg::MAX_TASKS];
	int unsigned used_slots;
	logic [11:0] wd_count;
	int unsigned presc_count;

	// Wrapped distance since the last heartbeat against the deadline.
	function automatic logic slot_is_late(int unsigned idx);
		logic [31:0] elapsed;
		elapsed = tick_now - heartbeat[idx];
		return elapsed > deadline_cfg;
	endfunction

	// Applies one input word to the shadow state and returns the result word it causes.
	function automatic mthw_pkg::result_t predict_result(logic [2:0] fn, logic [3:0] slot);
		mthw_pkg::result_t r;
		int unsigned       div;
		r = '0;
		case (fn)
			mthw_pkg::FN_TICK: begin
				tick_now = tick_now + 32'd1;
			end
			mthw_pkg::FN_WDCLK: begin
				if (enable_cfg) begin
					// out-of-range dividers clamp to 1..256
					div = 32'(divider_cfg);
					if (div == 0) div = 1;
					if (div > 256) div = 256;
					if (presc_count + 1 >= div) begin
						presc_count = 0;
						if (wd_count <= 12'd1) begin
							// expiry: clear everything but the registers
							r.reset_request = 1'b1;
							tick_now = '0;
							for (int i = 0; i < mthw_pkg::MAX_TASKS; i++) live[i] = 1'b0;
							used_slots = 0;
							wd_count = reload_cfg;
							n_expiry++;
						end else begin
							wd_count = wd_count - 12'd1;
						end
					end else begin
						presc_count++;
					end
				end
			end
			mthw_pkg::FN_REGISTER: begin
				if (used_slots < mthw_pkg::MAX_TASKS) begin
					r.slot_out = used_slots[2:0];
					r.accepted = 1'b1;
					heartbeat[used_slots] = tick_now;
					live[used_slots] = 1'b1;
					used_slots++;
				end else begin
					n_full++;
				end
			end
			mthw_pkg::FN_CHECKIN: begin
				if (slot < mthw_pkg::MAX_TASKS && live[slot]) begin
					heartbeat[slot] = tick_now;
					r.accepted = 1'b1;
				end
			end
			mthw_pkg::FN_CHECK: begin
				r.no_stall = 1'b1;
				for (int i = 0; i < used_slots; i++) begin
					if (live[i] && slot_is_late(i)) begin
						r.no_stall = 1'b0;
						r.stalled_mask[i] = 1'b1;
					end
				end
				// feed happens even with the watchdog disabled
				if (r.no_stall) begin
					wd_count = reload_cfg;
					r.fed = 1'b1;
				end else begin
					n_late_checks++;
				end
			end
			mthw_pkg::FN_QUERY: begin
				if (slot < mthw_pkg::MAX_TASKS && live[slot] && slot_is_late(slot))
					r.stalled = 1'b1;
			end
			default: ;
		endcase
		r.task_count = used_slots[3:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- checking
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// ---------------------------------------------------------------- driver
	// Predicts at the edge a word is taken, then offers the next one unless idling.
	always @(posedge clk) begin : tx_side
		hb_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_result(s_tuser, s_tdata[3:0]));
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (word_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					w = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= w.func;
					s_tdata  <= {4'b0000, w.slot};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// Compares each result word with the oldest prediction; owns m_tready and
	// the long back-pressure stretch.
	int unsigned rx_hold_seen = 0;
	int unsigned rx_hold_left = 0;

	always @(posedge clk) begin : rx_side
		mthw_pkg::result_t got;
		mthw_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = mthw_pkg::result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result word with none pending, expected nothing, actual %h",
							$time, m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("slot_out",      32'(want.slot_out),      32'(got.slot_out));
					check_field("accepted",      32'(want.accepted),      32'(got.accepted));
					check_field("stalled",       32'(want.stalled),       32'(got.stalled));
					check_field("no_stall",      32'(want.no_stall),      32'(got.no_stall));
					check_field("fed",           32'(want.fed),           32'(got.fed));
					check_field("stalled_mask",  32'(want.stalled_mask),  32'(got.stalled_mask));
					check_field("reset_request", 32'(want.reset_request), 32'(got.reset_request));
					check_field("task_count",    32'(want.task_count),    32'(got.task_count));
					results_checked++;
				end
			end
			if (rx_hold_seen != rx_hold_reqs) begin
				rx_hold_seen++;
				rx_hold_left = HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------- hang guard
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results still pending",
				$time, QUIET_LIMIT, expected_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequencer helpers
	task automatic queue_word(logic [2:0] fn, logic [3:0] slot);
		hb_word_t w;
		w.func = fn;
		w.slot = slot;
		word_q.push_back(w);
		words_queued++;
	endtask

	// APB write, then read back; shadow registers follow the write.
	task automatic program_reg(mthw_pkg::reg_idx_t idx, logic [31:0] val);
		logic [31:0] mask;
		logic [31:0] rd;
		case (idx)
			mthw_pkg::REG_DEADLINE: mask = 32'hFFFF_FFFF;
			mthw_pkg::REG_RELOAD:   mask = 32'h0000_0FFF;
			mthw_pkg::REG_DIVIDER:  mask = 32'h0000_01FF;
			default:                mask = 32'h0000_0001;
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			mthw_pkg::REG_DEADLINE: deadline_cfg = val;
			mthw_pkg::REG_RELOAD:   reload_cfg   = val[11:0];
			mthw_pkg::REG_DIVIDER:  divider_cfg  = val[8:0];
			default:                enable_cfg   = val[0];
		endcase
		// read back
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rd = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_field("prdata", val & mask, rd);
	endtask

	task automatic set_cfg(logic [31:0] dl, logic [31:0] rl, logic [31:0] dv, logic [31:0] en);
		program_reg(mthw_pkg::REG_DEADLINE, dl);
		program_reg(mthw_pkg::REG_RELOAD, rl);
		program_reg(mthw_pkg::REG_DIVIDER, dv);
		program_reg(mthw_pkg::REG_ENABLE, en);
		n_settings++;
	endtask

	// Sender pause: everything queued is taken and every result is back.
	task automatic wait_idle();
		while (words_sent != words_queued || expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A burst of registrations, then a mixed stream biased toward slots 0 to 7.
	task automatic queue_random(int unsigned n);
		int unsigned pick;
		logic [3:0]  slot;
		repeat ($urandom_range(1, 9))
			queue_word(mthw_pkg::FN_REGISTER, 4'($urandom_range(0, 15)));
		repeat (n) begin
			pick = $urandom_range(99);
			slot = ($urandom_range(99) < 85) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
			if (pick < 28)      queue_word(mthw_pkg::FN_TICK, slot);
			else if (pick < 42) queue_word(mthw_pkg::FN_WDCLK, slot);
			else if (pick < 52) queue_word(mthw_pkg::FN_REGISTER, slot);
			else if (pick < 72) queue_word(mthw_pkg::FN_CHECKIN, slot);
			else if (pick < 82) queue_word(mthw_pkg::FN_CHECK, slot);
			else if (pick < 96) queue_word(mthw_pkg::FN_QUERY, slot);
			else if (pick < 98) queue_word(FN_UNDEF_6, slot);
			else                queue_word(FN_UNDEF_7, slot);
		end
	endtask

	// ---------------------------------------------------------------- sequencer
	initial begin
		// shadow state at reset
		deadline_cfg = mthw_pkg::DEADLINE_RST;
		reload_cfg   = mthw_pkg::RELOAD_RST;
		divider_cfg  = mthw_pkg::DIVIDER_RST;
		enable_cfg   = 1'b1;
		tick_now     = '0;
		used_slots   = 0;
		wd_count     = mthw_pkg::WDT_RESET_LOAD;
		presc_count  = 0;
		for (int i = 0; i < mthw_pkg::MAX_TASKS; i++) live[i] = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: tight deadline and reload so every corner shows in a few words
		tx_idle_pct = 24;
		rx_idle_pct = 62;
		set_cfg(32'd1, 32'd2, 32'd1, 32'd1);
		queue_word(mthw_pkg::FN_CHECK, 4'd0);       // empty table feeds
		queue_word(mthw_pkg::FN_QUERY, 4'd0);       // unregistered slot answers 0
		queue_word(mthw_pkg::FN_CHECKIN, 4'd3);     // unregistered checkin refused
		for (int i = 0; i < 9; i++)                 // fill all eight, ninth hits full table
			queue_word(mthw_pkg::FN_REGISTER, 4'(i));
		queue_word(mthw_pkg::FN_CHECKIN, 4'd15);    // out of range
		queue_word(mthw_pkg::FN_QUERY, 4'd15);
		queue_word(mthw_pkg::FN_CHECKIN, 4'd8);
		queue_word(mthw_pkg::FN_TICK, 4'd0);
		queue_word(mthw_pkg::FN_TICK, 4'd0);        // elapsed 2 > deadline 1
		queue_word(mthw_pkg::FN_CHECKIN, 4'd7);     // slot 7 refreshed
		queue_word(mthw_pkg::FN_QUERY, 4'd0);       // late
		queue_word(mthw_pkg::FN_QUERY, 4'd7);       // fresh
		queue_word(mthw_pkg::FN_CHECK, 4'd0);       // seven late, no feed
		queue_word(FN_UNDEF_6, 4'd5);
		queue_word(FN_UNDEF_7, 4'd10);
		queue_word(mthw_pkg::FN_WDCLK, 4'd0);       // counter 2 -> 1
		queue_word(mthw_pkg::FN_WDCLK, 4'd0);       // expiry clears the table
		queue_word(mthw_pkg::FN_REGISTER, 4'd0);    // slot 0 again
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			// settings sweep, extremes included: dividers 0 and 511 clamp, reload 0
			// expires on the first decrement, deadline 0 makes any tick late
			case (p)
				0: set_cfg(32'd8, 32'd6, 32'd2, 32'd1);
				1: set_cfg(32'hFFFF_FFFF, 32'd4095, 32'd256, 32'd1);
				2: set_cfg(32'd1, 32'd1, 32'd0, 32'd1);
				3: set_cfg(32'd20, 32'd3, 32'd511, 32'd1);
				4: set_cfg(32'd3, 32'd0, 32'd1, 32'd0);
				5: set_cfg(32'd12, 32'd5, 32'd3, 32'd1);
				6: set_cfg(32'd0, 32'd2, 32'd1, 32'd1);
				7: set_cfg(32'd2000, 32'd1875, 32'd64, 32'd1);
				default: set_cfg($urandom_range(1, 40), $urandom_range(1, 20),
					$urandom_range(1, 8), 32'd1);
			endcase
			if (p < 3) begin
				tx_idle_pct = 24;
				rx_idle_pct = 62;
			end else if (p < 6) begin
				tx_idle_pct = 62;
				rx_idle_pct = 24;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			queue_random(PHASE_WORDS);
			// receiver stalls long while the sender keeps offering
			if (p == 1 || p == 7) rx_hold_reqs++;
			wait_idle();
		end

		$display("covered %0d words, %0d results checked, %0d watchdog expiries",
			words_sent, results_checked, n_expiry);
		$display("%0d checks with late slots, %0d full-table registers, %0d register settings",
			n_late_checks, n_full, n_settings);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
